### design/gillespie_hop_decay_step_core_macros.svh
// Assertion helpers for the hop/decay step core.
// Each macro samples on posedge clk and is disabled while rst is high.
`ifndef GILLESPIE_HOP_DECAY_STEP_CORE_MACROS_SVH
`define GILLESPIE_HOP_DECAY_STEP_CORE_MACROS_SVH

// Same-cycle implication.
`define GHDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define GHDS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/ghds_pkg.sv
// ----------------------------------------------------------------------------
// ghds_pkg
// Types and constants for the hop/decay stochastic step core.
// ----------------------------------------------------------------------------
package ghds_pkg;

  localparam int SITES_DEF      = 100;
  localparam int COUNT_BITS_DEF = 16;

  // ln(2) in Q0.32
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  // item kinds
  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_STEP = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // register indexes
  localparam logic [2:0] CFG_HOP_RATE      = 3'd0;
  localparam logic [2:0] CFG_DECAY_RATE    = 3'd1;
  localparam logic [2:0] CFG_INFLUX_FACTOR = 3'd2;
  localparam logic [2:0] CFG_START_TIME    = 3'd3;
  localparam logic [2:0] CFG_END_TIME      = 3'd4;

  // register reset values
  localparam logic [15:0] HOP_RATE_RST      = 16'd58982;
  localparam logic [15:0] DECAY_RATE_RST    = 16'd655;
  localparam logic [7:0]  INFLUX_FACTOR_RST = 8'd15;
  localparam logic [31:0] START_TIME_RST    = 32'd0;
  localparam logic [31:0] END_TIME_RST      = 32'd655360000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  site;
    logic [15:0] count_value;
    logic [15:0] rand_time;
    logic [15:0] rand_pick;
  } ghds_in_t;

  typedef struct packed {
    logic [8:0]  channel;
    logic [31:0] event_time;
    logic        finished;
    logic [15:0] count_out;
  } ghds_out_t;

  // position of the highest set bit (input nonzero)
  function automatic logic [3:0] msb16(input logic [15:0] r);
    logic [3:0] e;
    e = 4'd0;
    for (int i = 1; i < 16; i++) begin
      if (r[i]) e = 4'(i);
    end
    return e;
  endfunction

endpackage

### design/gillespie_hop_decay_step_core.sv
// ----------------------------------------------------------------------------
// gillespie_hop_decay_step_core
// Direct-method stochastic step on a chain of sites, counts in one memory.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one item: load a site count, take one
//   reaction step, or read a site count. Every item gives exactly one
//   result on out_valid/out_ready/out_data.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the rate and time registers;
//   cfg_ready is always high. Writing start_time also reloads the time and
//   clears the finished flag.
//   A load goes straight to the result and a read waits on the count memory.
//   A full step sums the 3*SITES-1 channels in one pass through the single
//   count memory read port, runs the log, the division and the threshold,
//   picks the channel in a second pass, then updates the counts.
//   One item is in work at a time; in_ready is high only while idle.
//   After reset the count memory is cleared, one entry per cycle, over all
//   SITES entries; in_ready stays low during that sweep.
//   A stalled receiver holds the result in the output register; the core
//   finishes the next item and then waits until the register is free.
// ----------------------------------------------------------------------------
`include "gillespie_hop_decay_step_core_macros.svh"

module gillespie_hop_decay_step_core #(
  parameter int SITES      = ghds_pkg::SITES_DEF,
  parameter int COUNT_BITS = ghds_pkg::COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ghds_pkg::ghds_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ghds_pkg::ghds_out_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int NCHAN = 3 * SITES - 1;
  localparam int AW    = $clog2(SITES);
  localparam int CW    = $clog2(NCHAN);
  localparam int PW    = 16 + COUNT_BITS;
  localparam int DIV_W = 37;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RD_WAIT, S_SUM_RUN, S_LN_MUL, S_LN_ADJ, S_LN_SCALE,
    S_LN_DONE, S_DIV, S_THR, S_PICK0, S_PICK_RUN, S_CHECK,
    S_AP_RDD, S_AP_WRD, S_AP_RDI, S_AP_WRI, S_FIN
  } state_t;

  typedef enum logic [1:0] {SEG_R, SEG_L, SEG_D} seg_t;

  state_t state;

  // configuration and step state
  logic [15:0] hop_rate, decay_rate;
  logic [7:0]  influx_factor;
  logic [31:0] start_time, end_time, sim_time;
  logic        done_flag;

  // count memory
  logic [COUNT_BITS-1:0] mem [SITES];
  logic [COUNT_BITS-1:0] mem_q, mem_wdata;
  logic [AW-1:0]         mem_waddr, mem_raddr, clr_addr;
  logic                  mem_we;

  // latched item and result
  ghds_pkg::ghds_in_t item;
  logic          item_in_range;
  logic [CW-1:0] res_chan;
  logic [15:0]   res_cnt;
  logic          res_zero;

  // channel stream
  seg_t          seg;
  logic [AW-1:0] st_site;
  logic [CW-1:0] iss_chan, s1_chan, s2_chan, pick;
  logic          iss_run, s1_v, s1_dec, s2_v, pick_pass, found;
  logic [PW-1:0] s2_p, prod;
  logic [63:0]   acc, acc_nx, sum;

  // log, divide, threshold
  logic [31:0]      ln_m;
  logic [63:0]      ln_m2;
  logic [33:0]      ln_t;
  logic [3:0]       ln_e, ln_i;
  logic [15:0]      ln_frac;
  logic [52:0]      nl_prod;
  logic [20:0]      ln_big;
  logic [DIV_W-1:0] quo;
  logic [63:0]      rem;
  logic [64:0]      rem_sh;
  logic [5:0]       div_cnt;
  logic [79:0]      thr_acc;
  logic [1:0]       thr_k;
  logic [15:0]      thr_chunk;
  logic [63:0]      thr;
  logic [37:0]      nt;

  // apply decode
  logic [CW-1:0] chan_sel;
  logic [31:0]   c32, dec32, inc32;
  logic          has_dec, has_inc;
  logic [AW-1:0] ap_dec, ap_inc;
  logic          ap_has_inc;

  // input side helpers
  logic [31:0]           in_site32, cv32, cvm32, q32;
  logic                  in_range;
  logic [AW-1:0]         in_addr;
  logic [COUNT_BITS-1:0] cv_mask;
  logic [15:0]           r_time;
  logic [3:0]            r_e;
  logic [23:0]           infl_prop;
  logic                  in_acc;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;

  assign in_site32 = 32'(in_data.site);
  assign in_range  = in_site32 < 32'(SITES);
  assign in_addr   = in_site32[AW-1:0];
  assign cv32      = 32'(in_data.count_value);
  assign cv_mask   = cv32[COUNT_BITS-1:0];
  assign cvm32     = 32'(cv_mask);
  assign q32       = 32'(mem_q);
  assign infl_prop = 24'(hop_rate) * 24'(influx_factor);

  assign r_time = (item.rand_time == 16'd0) ? 16'd1 : item.rand_time;
  assign r_e    = ghds_pkg::msb16(r_time);

  // stream datapath
  assign prod   = PW'(s1_dec ? decay_rate : hop_rate) * PW'(mem_q);
  assign acc_nx = acc + 64'(s2_p);

  // log, divide and threshold datapath
  assign ln_t      = 34'(ln_m2 >> 30);
  assign ln_big    = (21'd16 << 16) - 21'({ln_e, ln_frac});
  assign rem_sh    = {rem, quo[DIV_W-1]};
  assign thr_chunk = sum[16*thr_k +: 16];
  assign thr       = thr_acc[79:16];
  assign nt        = 38'(sim_time) + 38'(quo);

  // channel to site decode
  assign chan_sel = found ? pick : CW'(NCHAN - 1);
  assign c32      = 32'(chan_sel);
  always_comb begin
    has_dec = 1'b1;
    has_inc = 1'b1;
    dec32   = '0;
    inc32   = '0;
    priority if (c32 == 32'd0) begin
      has_dec = 1'b0;
    end else if (c32 < 32'(SITES)) begin
      dec32 = c32 - 32'd1;
      inc32 = c32;
    end else if (c32 < 32'(2 * SITES - 1)) begin
      dec32 = 32'(2 * SITES - 1) - c32;
      inc32 = 32'(2 * SITES - 2) - c32;
    end else begin
      dec32   = c32 - 32'(2 * SITES - 1);
      has_inc = 1'b0;
    end
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    mem_raddr = in_addr;
    unique case (state)
      S_CLEAR: mem_we = 1'b1;
      S_IDLE: begin
        if (in_valid && in_data.kind == ghds_pkg::KIND_LOAD && in_range) begin
          mem_we    = 1'b1;
          mem_waddr = in_addr;
          mem_wdata = cv_mask;
        end
      end
      S_SUM_RUN, S_PICK_RUN: mem_raddr = st_site;
      S_AP_RDD: mem_raddr = ap_dec;
      S_AP_WRD: begin
        mem_we    = 1'b1;
        mem_waddr = ap_dec;
        mem_wdata = (mem_q == '0) ? mem_q : mem_q - 1'b1;
      end
      S_AP_RDI: mem_raddr = ap_inc;
      S_AP_WRI: begin
        mem_we    = 1'b1;
        mem_waddr = ap_inc;
        mem_wdata = (&mem_q) ? mem_q : mem_q + 1'b1;
      end
      default: ;
    endcase
  end

  // count memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_q <= mem[mem_raddr];
  end

  // control, registers and result
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      hop_rate      <= ghds_pkg::HOP_RATE_RST;
      decay_rate    <= ghds_pkg::DECAY_RATE_RST;
      influx_factor <= ghds_pkg::INFLUX_FACTOR_RST;
      start_time    <= ghds_pkg::START_TIME_RST;
      end_time      <= ghds_pkg::END_TIME_RST;
      sim_time      <= ghds_pkg::START_TIME_RST;
      done_flag     <= 1'b0;
      out_valid     <= 1'b0;
      iss_run       <= 1'b0;
      s1_v          <= 1'b0;
      s2_v          <= 1'b0;
    end else begin
      // result taken; the finish state sets it again on its own
      if (out_valid && out_ready && state != S_FIN) out_valid <= 1'b0;

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(SITES - 1)) state <= S_IDLE;
        end

        S_IDLE: begin
          if (in_acc) begin
            item          <= in_data;
            item_in_range <= in_range;
            res_chan      <= '0;
            res_cnt       <= '0;
            res_zero      <= 1'b0;
            priority case (in_data.kind)
              ghds_pkg::KIND_LOAD: begin
                if (in_range) res_cnt <= cvm32[15:0];
                state <= S_FIN;
              end
              ghds_pkg::KIND_READ: state <= S_RD_WAIT;
              ghds_pkg::KIND_STEP: begin
                if (done_flag || sim_time >= end_time) begin
                  sim_time  <= end_time;
                  done_flag <= 1'b1;
                  state     <= S_FIN;
                end else begin
                  acc       <= 64'(infl_prop);
                  pick_pass <= 1'b0;
                  seg       <= SEG_R;
                  st_site   <= '0;
                  iss_chan  <= CW'(1);
                  iss_run   <= 1'b1;
                  state     <= S_SUM_RUN;
                end
              end
              default: begin
                res_zero <= 1'b1;
                state    <= S_FIN;
              end
            endcase
          end
        end

        S_RD_WAIT: begin
          if (item_in_range) res_cnt <= q32[15:0];
          state <= S_FIN;
        end

        S_SUM_RUN, S_PICK_RUN: begin
          // issue one channel per cycle
          s1_v    <= iss_run;
          s1_chan <= iss_chan;
          s1_dec  <= (seg == SEG_D);
          if (iss_run) begin
            iss_chan <= iss_chan + 1'b1;
            unique case (seg)
              SEG_R: begin
                if (st_site == AW'(SITES - 2)) begin
                  seg     <= SEG_L;
                  st_site <= AW'(SITES - 1);
                end else begin
                  st_site <= st_site + 1'b1;
                end
              end
              SEG_L: begin
                if (st_site == AW'(1)) begin
                  seg     <= SEG_D;
                  st_site <= '0;
                end else begin
                  st_site <= st_site - 1'b1;
                end
              end
              default: begin
                if (st_site == AW'(SITES - 1)) iss_run <= 1'b0;
                else st_site <= st_site + 1'b1;
              end
            endcase
          end
          // product stage
          s2_v    <= s1_v;
          s2_chan <= s1_chan;
          s2_p    <= prod;
          // running sum and first crossing
          if (s2_v) begin
            acc <= acc_nx;
            if (pick_pass && !found && acc_nx >= thr) begin
              found <= 1'b1;
              pick  <= s2_chan;
            end
          end
          if (!iss_run && !s1_v && !s2_v) begin
            if (state == S_PICK_RUN) begin
              state <= S_CHECK;
            end else if (acc == 64'd0) begin
              sim_time  <= end_time;
              done_flag <= 1'b1;
              state     <= S_FIN;
            end else begin
              sum     <= acc;
              ln_e    <= r_e;
              ln_m    <= 32'(r_time) << (5'd30 - 5'(r_e));
              ln_i    <= '0;
              ln_frac <= '0;
              state   <= S_LN_MUL;
            end
          end
        end

        S_LN_MUL: begin
          ln_m2 <= 64'(ln_m) * 64'(ln_m);
          state <= S_LN_ADJ;
        end

        S_LN_ADJ: begin
          if (ln_t[31]) begin
            ln_m    <= ln_t[32:1];
            ln_frac <= {ln_frac[14:0], 1'b1};
          end else begin
            ln_m    <= ln_t[31:0];
            ln_frac <= {ln_frac[14:0], 1'b0};
          end
          ln_i <= ln_i + 1'b1;
          state <= (ln_i == 4'd15) ? S_LN_SCALE : S_LN_MUL;
        end

        S_LN_SCALE: begin
          nl_prod <= 53'(ln_big) * 53'(ghds_pkg::LN2_Q32);
          state   <= S_LN_DONE;
        end

        S_LN_DONE: begin
          quo     <= DIV_W'(nl_prod[52:32]) << 16;
          rem     <= '0;
          div_cnt <= '0;
          state   <= S_DIV;
        end

        // restoring division, one quotient bit per cycle
        S_DIV: begin
          if (rem_sh >= 65'(sum)) begin
            rem <= 64'(rem_sh - 65'(sum));
            quo <= {quo[DIV_W-2:0], 1'b1};
          end else begin
            rem <= rem_sh[63:0];
            quo <= {quo[DIV_W-2:0], 1'b0};
          end
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == 6'(DIV_W - 1)) begin
            thr_acc <= '0;
            thr_k   <= 2'd3;
            state   <= S_THR;
          end
        end

        // sum * rand_pick, 16 bits of sum per cycle from the top
        S_THR: begin
          thr_acc <= (thr_acc << 16) + 80'(32'(thr_chunk) * 32'(item.rand_pick));
          if (thr_k == 2'd0) state <= S_PICK0;
          else thr_k <= thr_k - 1'b1;
        end

        S_PICK0: begin
          acc       <= 64'(infl_prop);
          found     <= (64'(infl_prop) >= thr);
          pick      <= '0;
          pick_pass <= 1'b1;
          seg       <= SEG_R;
          st_site   <= '0;
          iss_chan  <= CW'(1);
          iss_run   <= 1'b1;
          state     <= S_PICK_RUN;
        end

        S_CHECK: begin
          res_chan   <= chan_sel;
          ap_dec     <= dec32[AW-1:0];
          ap_inc     <= inc32[AW-1:0];
          ap_has_inc <= has_inc;
          if (nt > 38'(end_time)) begin
            sim_time  <= end_time;
            done_flag <= 1'b1;
            state     <= S_FIN;
          end else begin
            sim_time <= nt[31:0];
            if (nt == 38'(end_time)) done_flag <= 1'b1;
            state <= has_dec ? S_AP_RDD : S_AP_RDI;
          end
        end

        S_AP_RDD: state <= S_AP_WRD;
        S_AP_WRD: state <= ap_has_inc ? S_AP_RDI : S_FIN;
        S_AP_RDI: state <= S_AP_WRI;
        S_AP_WRI: state <= S_FIN;

        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            if (res_zero) begin
              out_data <= '0;
            end else begin
              out_data.channel    <= 9'(res_chan);
              out_data.event_time <= sim_time;
              out_data.finished   <= done_flag;
              out_data.count_out  <= res_cnt;
            end
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase

      // register writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          ghds_pkg::CFG_HOP_RATE:      hop_rate      <= cfg_data[15:0];
          ghds_pkg::CFG_DECAY_RATE:    decay_rate    <= cfg_data[15:0];
          ghds_pkg::CFG_INFLUX_FACTOR: influx_factor <= cfg_data[7:0];
          ghds_pkg::CFG_START_TIME: begin
            start_time <= cfg_data;
            sim_time   <= cfg_data;
            done_flag  <= 1'b0;
          end
          ghds_pkg::CFG_END_TIME:      end_time      <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // checks
  `GHDS_ASSERT_IMP(a_no_write_in_walk, (state == S_SUM_RUN || state == S_PICK_RUN), !mem_we, "count memory written during a channel walk")
  `GHDS_ASSERT_NXT(a_done_sticky, (done_flag && !(cfg_valid && cfg_index == ghds_pkg::CFG_START_TIME)), done_flag, "finished flag cleared without a start time write")
  `GHDS_ASSERT_IMP(a_stream_idle, (state != S_SUM_RUN && state != S_PICK_RUN), (!s1_v && !s2_v), "channel stream active outside a walk")
  `GHDS_ASSERT_IMP(a_clear_blocks, (state == S_CLEAR), (!in_ready && !out_valid), "item handshake during memory clear")

endmodule

### tb/gillespie_hop_decay_step_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gillespie_hop_decay_step_core_tb
// Self-checking bench for the hop/decay stochastic step core. A directed
// table runs first, then random load, step, read and unused-kind items over
// several rate and time settings. Every result is checked against a table
// value or an in-bench model of the chain, its clock and its finished flag.
// ----------------------------------------------------------------------------
module gillespie_hop_decay_step_core_tb;

  localparam int NSITE = 100;
  localparam int NCHAN = 3 * NSITE - 1;
  localparam logic [1:0] KIND_NONE = 2'd3;

  typedef struct {
    ghds_pkg::ghds_in_t  item;
    bit                  typed;
    ghds_pkg::ghds_out_t want;
  } table_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  ghds_pkg::ghds_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  ghds_pkg::ghds_out_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // chain model state and registers
  logic [15:0] chain_counts [NSITE];
  logic [31:0] chain_time;
  bit          chain_done;
  logic [15:0] hop_rate_m, decay_rate_m;
  logic [7:0]  influx_m;
  logic [31:0] end_time_m;

  ghds_pkg::ghds_out_t pending_results [$];
  table_row_t  rows [$];
  bit          failed = 1'b0;

  gillespie_hop_decay_step_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // -ln(r) in Q16.16 via bitwise log2
  function automatic longint unsigned neg_log_q16(logic [15:0] r_in);
    longint unsigned m, l2, big;
    logic [31:0] r;
    logic [15:0] fr;
    int e;
    r = 32'(r_in);
    if (r == 0) r = 1;
    e = 0;
    fr = '0;
    while (e < 15 && (r >> (e + 1)) != 0) e++;
    m = 64'(r) << (30 - e);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      fr = fr << 1;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        fr[0] = 1'b1;
      end
    end
    l2 = (64'(e) << 16) | 64'(fr);
    big = (64'd16 << 16) - l2;
    return (big * 64'(ghds_pkg::LN2_Q32)) >> 32;
  endfunction

  function automatic void bump_up(int s);
    if (chain_counts[s] != 16'hFFFF) chain_counts[s] = chain_counts[s] + 1;
  endfunction

  function automatic void bump_down(int s);
    if (chain_counts[s] != 0) chain_counts[s] = chain_counts[s] - 1;
  endfunction

  // expected result of one item; advances the chain model
  function automatic ghds_pkg::ghds_out_t predict_item(ghds_pkg::ghds_in_t it);
    ghds_pkg::ghds_out_t r;
    longint unsigned prop [NCHAN];
    longint unsigned sum, thr, s, tau, nt, rate;
    int c, src;
    r = '0;
    if (it.kind == KIND_NONE) return r;
    if (it.kind == ghds_pkg::KIND_LOAD) begin
      if (it.site < NSITE) begin
        chain_counts[it.site] = it.count_value;
        r.count_out = it.count_value;
      end
    end else if (it.kind == ghds_pkg::KIND_READ) begin
      if (it.site < NSITE) r.count_out = chain_counts[it.site];
    end else if (chain_done || chain_time >= end_time_m) begin
      chain_time = end_time_m;
      chain_done = 1'b1;
    end else begin
      prop[0] = 64'(hop_rate_m) * 64'(influx_m);
      sum = prop[0];
      for (c = 1; c < NCHAN; c++) begin
        rate = 64'(hop_rate_m);
        if (c < NSITE) src = c - 1;
        else if (c < 2 * NSITE - 1) src = 2 * NSITE - 1 - c;
        else begin
          src = c - (2 * NSITE - 1);
          rate = 64'(decay_rate_m);
        end
        prop[c] = rate * 64'(chain_counts[src]);
        sum += prop[c];
      end
      if (sum == 0) begin
        chain_time = end_time_m;
        chain_done = 1'b1;
      end else begin
        tau = (neg_log_q16(it.rand_time) << 16) / sum;
        thr = (sum >> 16) * 64'(it.rand_pick) + (((sum & 64'hFFFF) * 64'(it.rand_pick)) >> 16);
        c = 0;
        s = prop[0];
        while (s < thr && c + 1 < NCHAN) begin
          c++;
          s += prop[c];
        end
        r.channel = 9'(c);
        nt = 64'(chain_time) + tau;
        if (nt > 64'(end_time_m)) begin
          chain_time = end_time_m;
          chain_done = 1'b1;
        end else begin
          if (c == 0) bump_up(0);
          else if (c < NSITE) begin
            bump_down(c - 1);
            bump_up(c);
          end else if (c < 2 * NSITE - 1) begin
            bump_down(2 * NSITE - 1 - c);
            bump_up(2 * NSITE - 2 - c);
          end else bump_down(c - (2 * NSITE - 1));
          chain_time = nt[31:0];
          if (nt == 64'(end_time_m)) chain_done = 1'b1;
        end
      end
    end
    r.event_time = chain_time;
    r.finished = chain_done;
    return r;
  endfunction

  function automatic ghds_pkg::ghds_in_t mk_item(logic [1:0] k, logic [6:0] st,
                                                 logic [15:0] cv, logic [15:0] rt,
                                                 logic [15:0] rp);
    ghds_pkg::ghds_in_t it;
    it.kind = k;
    it.site = st;
    it.count_value = cv;
    it.rand_time = rt;
    it.rand_pick = rp;
    return it;
  endfunction

  function automatic ghds_pkg::ghds_out_t mk_result(logic [15:0] cnt);
    ghds_pkg::ghds_out_t o;
    o = '0;
    o.count_out = cnt;
    return o;
  endfunction

  function automatic void add_row(ghds_pkg::ghds_in_t it, bit typed,
                                  ghds_pkg::ghds_out_t want);
    table_row_t row;
    row.item = it;
    row.typed = typed;
    row.want = want;
    rows.push_back(row);
  endfunction

  function automatic ghds_pkg::ghds_in_t rand_item();
    ghds_pkg::ghds_in_t it;
    int k;
    k = $urandom_range(0, 99);
    if (k < 25) it.kind = ghds_pkg::KIND_LOAD;
    else if (k < 75) it.kind = ghds_pkg::KIND_STEP;
    else if (k < 95) it.kind = ghds_pkg::KIND_READ;
    else it.kind = KIND_NONE;
    it.site = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(100, 127))
                                          : 7'($urandom_range(0, 99));
    k = $urandom_range(0, 9);
    if (k < 6) it.count_value = 16'($urandom_range(0, 15));
    else if (k < 8) it.count_value = 16'($urandom);
    else it.count_value = 16'($urandom_range(65530, 65535));
    it.rand_time = ($urandom_range(0, 31) == 0) ? 16'd0 : 16'($urandom);
    it.rand_pick = ($urandom_range(0, 31) == 0) ? 16'd0 : 16'($urandom);
    return it;
  endfunction

  // send one item; expectation is queued at acceptance
  task automatic send_item(ghds_pkg::ghds_in_t it, bit typed, ghds_pkg::ghds_out_t want);
    ghds_pkg::ghds_out_t exp_r;
    repeat ($urandom_range(0, 12)) @(negedge clk);
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (!in_ready);
    exp_r = predict_item(it);
    pending_results.push_back(typed ? want : exp_r);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ghds_pkg::CFG_HOP_RATE:      hop_rate_m = val[15:0];
      ghds_pkg::CFG_DECAY_RATE:    decay_rate_m = val[15:0];
      ghds_pkg::CFG_INFLUX_FACTOR: influx_m = val[7:0];
      ghds_pkg::CFG_START_TIME: begin
        chain_time = val;
        chain_done = 1'b0;
      end
      ghds_pkg::CFG_END_TIME:      end_time_m = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_regs(logic [15:0] hr, logic [15:0] dr, logic [7:0] inf,
                          logic [31:0] st, logic [31:0] et);
    wait_idle();
    write_reg(ghds_pkg::CFG_HOP_RATE, 32'(hr));
    write_reg(ghds_pkg::CFG_DECAY_RATE, 32'(dr));
    write_reg(ghds_pkg::CFG_INFLUX_FACTOR, 32'(inf));
    write_reg(ghds_pkg::CFG_END_TIME, et);
    write_reg(ghds_pkg::CFG_START_TIME, st);
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) send_item(rand_item(), 1'b0, '0);
  endtask

  // receiver: random stall before each result
  initial begin
    forever begin
      @(negedge clk);
      out_ready = 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk);
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // result checker
  always @(posedge clk) begin
    ghds_pkg::ghds_out_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected");
        failed = 1'b1;
      end else begin
        e = pending_results.pop_front();
        if (out_data.channel !== e.channel) begin
          $error("channel expected %0d actual %0d", e.channel, out_data.channel);
          failed = 1'b1;
        end
        if (out_data.event_time !== e.event_time) begin
          $error("event_time expected %0d actual %0d", e.event_time, out_data.event_time);
          failed = 1'b1;
        end
        if (out_data.finished !== e.finished) begin
          $error("finished expected %0d actual %0d", e.finished, out_data.finished);
          failed = 1'b1;
        end
        if (out_data.count_out !== e.count_out) begin
          $error("count_out expected %0d actual %0d", e.count_out, out_data.count_out);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    #50000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    for (int i = 0; i < NSITE; i++) chain_counts[i] = '0;
    hop_rate_m = ghds_pkg::HOP_RATE_RST;
    decay_rate_m = ghds_pkg::DECAY_RATE_RST;
    influx_m = ghds_pkg::INFLUX_FACTOR_RST;
    chain_time = ghds_pkg::START_TIME_RST;
    end_time_m = ghds_pkg::END_TIME_RST;
    chain_done = 1'b0;

    // directed table; typed rows come before any step
    add_row(mk_item(ghds_pkg::KIND_READ, 7'd0, 16'd0, 16'd0, 16'd0), 1'b1, mk_result(16'd0));
    add_row(mk_item(ghds_pkg::KIND_READ, 7'd127, 16'd0, 16'd0, 16'd0), 1'b1,
            mk_result(16'd0));
    add_row(mk_item(KIND_NONE, 7'h7F, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1, mk_result(16'd0));
    add_row(mk_item(ghds_pkg::KIND_LOAD, 7'd5, 16'hFFFF, 16'd0, 16'd0), 1'b1,
            mk_result(16'hFFFF));
    add_row(mk_item(ghds_pkg::KIND_LOAD, 7'd100, 16'd7, 16'd0, 16'd0), 1'b1,
            mk_result(16'd0));
    add_row(mk_item(ghds_pkg::KIND_LOAD, 7'd0, 16'hFFFF, 16'd0, 16'd0), 1'b1,
            mk_result(16'hFFFF));
    add_row(mk_item(ghds_pkg::KIND_LOAD, 7'd99, 16'hFFFE, 16'd0, 16'd0), 1'b1,
            mk_result(16'hFFFE));
    add_row(mk_item(ghds_pkg::KIND_LOAD, 7'd1, 16'd3, 16'd0, 16'd0), 1'b1, mk_result(16'd3));
    add_row(mk_item(ghds_pkg::KIND_READ, 7'd5, 16'd0, 16'd0, 16'd0), 1'b1,
            mk_result(16'hFFFF));
    add_row(mk_item(ghds_pkg::KIND_STEP, 7'd0, 16'd0, 16'd0, 16'd0), 1'b0, '0);
    add_row(mk_item(ghds_pkg::KIND_STEP, 7'd0, 16'd0, 16'hFFFF, 16'hFFFF), 1'b0, '0);
    add_row(mk_item(ghds_pkg::KIND_STEP, 7'd0, 16'd0, 16'd1, 16'd1), 1'b0, '0);
    add_row(mk_item(ghds_pkg::KIND_STEP, 7'd0, 16'd0, 16'd32768, 16'd40000), 1'b0, '0);
    add_row(mk_item(ghds_pkg::KIND_READ, 7'd0, 16'd0, 16'd0, 16'd0), 1'b0, '0);
    add_row(mk_item(ghds_pkg::KIND_READ, 7'd1, 16'd0, 16'd0, 16'd0), 1'b0, '0);
    add_row(mk_item(ghds_pkg::KIND_STEP, 7'd0, 16'd0, 16'd100, 16'hFFFF), 1'b0, '0);
    add_row(mk_item(ghds_pkg::KIND_READ, 7'd99, 16'd0, 16'd0, 16'd0), 1'b0, '0);
    add_row(mk_item(ghds_pkg::KIND_STEP, 7'd0, 16'd0, 16'hFFFF, 16'd0), 1'b0, '0);
    add_row(mk_item(ghds_pkg::KIND_STEP, 7'd0, 16'd0, 16'd12345, 16'd65000), 1'b0, '0);
    add_row(mk_item(ghds_pkg::KIND_READ, 7'd98, 16'd0, 16'd0, 16'd0), 1'b0, '0);
    add_row(mk_item(KIND_NONE, 7'd3, 16'd9, 16'd9, 16'd9), 1'b0, '0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].want);
    run_random(180);

    // no propensity at all: every step ends the run
    set_regs(16'd0, 16'd0, 8'd0, 32'd0, ghds_pkg::END_TIME_RST);
    run_random(40);
    // largest rates, widest time span
    set_regs(16'hFFFF, 16'hFFFF, 8'hFF, 32'd0, 32'hFFFF_FFFF);
    run_random(180);
    // smallest rates near the top of time: long waits pass the end
    set_regs(16'd1, 16'd1, 8'd1, 32'hFFFF_0000, 32'hFFFF_FFFF);
    run_random(100);
    // start already at the end
    set_regs(ghds_pkg::HOP_RATE_RST, ghds_pkg::DECAY_RATE_RST, ghds_pkg::INFLUX_FACTOR_RST,
             32'd1000, 32'd1000);
    run_random(40);
    // random settings, one of them with a short window
    for (int p = 0; p < 4; p++) begin
      logic [31:0] st;
      st = $urandom;
      set_regs(16'($urandom), 16'($urandom), 8'($urandom), st,
               (p == 1) ? st + 32'($urandom_range(0, 20000))
                        : st | 32'h7FFF_FFFF);
      run_random(170);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
